// ===== sv/bds_pkg.sv =====
// Shared types and constants of the 2x2 box downsampler.
`timescale 1ns / 1ps
package bds_pkg;

	localparam int BDS_MAX_WIDTH = 2048;

	localparam int CHAN_W     = 8;
	localparam int PAIR_W     = CHAN_W + 1;
	localparam int ENTRY_W    = 3 * PAIR_W;
	localparam int PIXEL_W    = 3 * CHAN_W;
	localparam int QUAD_W     = CHAN_W + 2;
	localparam int TOTAL_W    = QUAD_W + 2;

	localparam int SRC_W      = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = SRC_W;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SOURCE_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRAY_MODE    = CFG_IDX_W'(1);

	localparam logic [SRC_W-1:0] SOURCE_WIDTH_RESET = SRC_W'(640);
	localparam int               MIN_WIDTH          = 2;

	// floor(s / 12) == (s * 2731) >> 15 for every s below 8192
	localparam int                 GRAY_RECIP_W = 12;
	localparam logic [GRAY_RECIP_W-1:0] GRAY_RECIP = GRAY_RECIP_W'(2731);
	localparam int                 GRAY_SHIFT   = 15;

	typedef struct packed {
		logic [PAIR_W-1:0] sum_c;
		logic [PAIR_W-1:0] sum_b;
		logic [PAIR_W-1:0] sum_a;
		logic              row_end;
		logic              gray;
	} bds_s1_t;

endpackage

// ===== sv/bds_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module bds_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bds_front.sv =====
// Input side: configuration, column/row tracking, pair sums and line buffer access.
`timescale 1ns / 1ps
module bds_front import bds_pkg::*; #(
	parameter int MAX_WIDTH = BDS_MAX_WIDTH,
	localparam int XW    = $clog2(MAX_WIDTH),
	localparam int DEPTH = MAX_WIDTH / 2,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int WW    = $clog2(MAX_WIDTH + 1),
	localparam int CW    = (WW > SRC_W) ? WW : SRC_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIXEL_W-1:0]    s_tdata,
	input  logic                  s_tuser,
	input  logic                  adv1,
	output logic                  s1_valid,
	output bds_s1_t               s1_data,
	output logic                  ram_we,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_addr,
	output logic [ENTRY_W-1:0]    ram_wdata
);

	logic [SRC_W-1:0]   width_q;
	logic               gray_q;
	logic [XW-1:0]      col_q;
	logic               odd_q;
	logic [PIXEL_W-1:0] hold_q;
	logic               valid_s1;
	bds_s1_t            data_s1;

	logic [CW-1:0]      sw_ext;
	logic [CW-1:0]      w_c;
	logic [CW-1:0]      pairs_c;
	logic [XW-1:0]      x_c;
	logic               odd_c;
	logic [XW-2:0]      pair_c;
	logic               in_range;
	logic               wrap;
	logic               acc;
	logic               pair_col;
	logic [PAIR_W-1:0]  sa, sb, sc;

	assign cfg_ready = 1'b1;

	always_comb begin
		sw_ext = CW'(width_q);
		if (sw_ext < CW'(MIN_WIDTH)) begin
			w_c = CW'(MIN_WIDTH);
		end else if (sw_ext > CW'(MAX_WIDTH)) begin
			w_c = CW'(MAX_WIDTH);
		end else begin
			w_c = sw_ext;
		end
		pairs_c = w_c >> 1;
	end

	assign x_c      = s_tuser ? '0 : col_q;
	assign odd_c    = s_tuser ? 1'b0 : odd_q;
	assign pair_c   = x_c[XW-1:1];
	assign in_range = (CW'(pair_c) < pairs_c) && (CW'(pair_c) < CW'(DEPTH));
	assign wrap     = (CW'(x_c) + CW'(1)) >= w_c;
	assign pair_col = x_c[0] && in_range;

	assign sa = PAIR_W'(s_tdata[CHAN_W-1:0]) + PAIR_W'(hold_q[CHAN_W-1:0]);
	assign sb = PAIR_W'(s_tdata[2*CHAN_W-1:CHAN_W]) + PAIR_W'(hold_q[2*CHAN_W-1:CHAN_W]);
	assign sc = PAIR_W'(s_tdata[3*CHAN_W-1:2*CHAN_W]) + PAIR_W'(hold_q[3*CHAN_W-1:2*CHAN_W]);

	assign s_tready  = !valid_s1 || adv1;
	assign acc       = s_tvalid && s_tready;
	assign ram_we    = acc && pair_col && !odd_c;
	assign ram_re    = acc && pair_col && odd_c;
	assign ram_addr  = AW'(pair_c);
	assign ram_wdata = {sc, sb, sa};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SOURCE_WIDTH_RESET;
			gray_q   <= 1'b0;
			col_q    <= '0;
			odd_q    <= 1'b0;
			hold_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_IDX_SOURCE_WIDTH: width_q <= cfg_data[SRC_W-1:0];
					CFG_IDX_GRAY_MODE:    gray_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (acc) begin
				if (!x_c[0]) begin
					hold_q <= s_tdata;
				end
				col_q <= wrap ? '0 : x_c + XW'(1);
				odd_q <= odd_c ^ wrap;
			end
			if (s_tready) begin
				valid_s1 <= ram_re;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			data_s1.sum_a   <= sa;
			data_s1.sum_b   <= sb;
			data_s1.sum_c   <= sc;
			data_s1.row_end <= (CW'(pair_c) + CW'(1)) == pairs_c;
			data_s1.gray    <= gray_q;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_data  = data_s1;

endmodule

// ===== sv/bds_back.sv =====
// Output side: block totals, gray divide by twelve and output register.
`timescale 1ns / 1ps
module bds_back import bds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s1_valid,
	input  bds_s1_t            s1_data,
	input  logic [ENTRY_W-1:0] rdata,
	output logic               adv1,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [PIXEL_W-1:0] m_tdata,
	output logic               m_tlast
);

	logic               valid_s2;
	logic [QUAD_W-1:0]  ta_s2, tb_s2, tc_s2;
	logic [TOTAL_W-1:0] total_s2;
	logic               gray_s2;
	logic               last_s2;

	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_data_q;
	logic               out_last_q;

	logic               adv2;
	logic [QUAD_W-1:0]  ta, tb, tc;
	logic [TOTAL_W+GRAY_RECIP_W-1:0] prod;
	logic [CHAN_W-1:0]  gray_val;

	assign adv2 = !out_valid_q || m_tready;
	assign adv1 = !valid_s2 || adv2;

	assign ta = QUAD_W'(s1_data.sum_a) + QUAD_W'(rdata[PAIR_W-1:0]);
	assign tb = QUAD_W'(s1_data.sum_b) + QUAD_W'(rdata[2*PAIR_W-1:PAIR_W]);
	assign tc = QUAD_W'(s1_data.sum_c) + QUAD_W'(rdata[3*PAIR_W-1:2*PAIR_W]);

	assign prod     = (TOTAL_W+GRAY_RECIP_W)'(total_s2) * (TOTAL_W+GRAY_RECIP_W)'(GRAY_RECIP);
	assign gray_val = prod[GRAY_SHIFT+CHAN_W-1:GRAY_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s2 <= s1_valid;
			end
			if (adv2) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s1_valid) begin
			ta_s2    <= ta;
			tb_s2    <= tb;
			tc_s2    <= tc;
			total_s2 <= TOTAL_W'(ta) + TOTAL_W'(tb) + TOTAL_W'(tc);
			gray_s2  <= s1_data.gray;
			last_s2  <= s1_data.row_end;
		end
		if (adv2 && valid_s2) begin
			if (gray_s2) begin
				out_data_q <= {gray_val, gray_val, gray_val};
			end else begin
				out_data_q <= {tc_s2[QUAD_W-1:2], tb_s2[QUAD_W-1:2], ta_s2[QUAD_W-1:2]};
			end
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/box_downsample_2x2.sv =====
// Top level of the 2x2 box-filter downsampler.
// Takes one 24-bit source pixel per clock in raster order and emits one pixel per 2x2
// block, so a stream of one pixel per clock is sustained with no gaps unless m_tready
// stalls the output. Even rows store per-pair channel sums in a single-port line buffer
// RAM of MAX_WIDTH/2 entries; odd rows read the entry back through the registered RAM
// read, complete the block in the stage-2 totals register and present it on m_* from
// the output register. While a result waits there, the pipeline keeps accepting until
// the stage-1 and stage-2 registers are full. The line buffer needs no clearing after
// reset. Gray mode divides the twelve-byte total by twelve with a constant reciprocal
// multiply. s_tuser is frame start; m_tlast marks the last pixel of each output row.
`timescale 1ns / 1ps
module box_downsample_2x2 import bds_pkg::*; #(
	parameter int MAX_WIDTH = BDS_MAX_WIDTH,
	localparam int DEPTH = MAX_WIDTH / 2,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,   // 0 source_width, 1 gray_mode
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIXEL_W-1:0]    s_tdata,     // chan_a, chan_b, chan_c
	input  logic                  s_tuser,     // frame_start
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIXEL_W-1:0]    m_tdata,     // out_a, out_b, out_c
	output logic                  m_tlast      // row_end
);

	logic               adv1;
	logic               s1_valid;
	bds_s1_t            s1_data;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	bds_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.adv1     (adv1),
		.s1_valid (s1_valid),
		.s1_data  (s1_data),
		.ram_we   (ram_we),
		.ram_re   (ram_re),
		.ram_addr (ram_addr),
		.ram_wdata(ram_wdata)
	);

	bds_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_line_buf (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	bds_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_valid(s1_valid),
		.s1_data (s1_data),
		.rdata   (ram_rdata),
		.adv1    (adv1),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

// ===== tb/tb_box_downsample_2x2.sv =====
// Self-checking testbench for box_downsample_2x2: directed and random pixel streams.
`timescale 1ns / 1ps
module tb_box_downsample_2x2;
	import bds_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int GRAY_DIV     = 12;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 48;
	localparam int WIDE_ITEMS   = 24;
	localparam int LS_AW        = $clog2(BDS_MAX_WIDTH / 2);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = CFG_IDX_W'(15);

	typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] c;
		logic              sof;
	} src_px_t;

	typedef struct packed {
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] c;
		logic              row_end;
	} box_px_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIXEL_W-1:0]    s_tdata;     // chan_a, chan_b, chan_c
	logic                  s_tuser;     // frame_start
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIXEL_W-1:0]    m_tdata;     // out_a, out_b, out_c
	logic                  m_tlast;     // row_end

	box_downsample_2x2 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// predictor state
	logic [ENTRY_W-1:0] line_sums [0:BDS_MAX_WIDTH/2-1];
	logic [SRC_W-1:0]   col_cnt;
	logic               odd_row;
	logic [PIXEL_W-1:0] left_px;
	logic [SRC_W-1:0]   width_reg;
	logic               gray_reg;

	src_px_t    pend_px[$];
	box_px_t    expected_px[$];
	idle_mode_t idle_mode;
	logic       src_taken;
	logic       cfg_taken;
	int         px_queued_cnt;
	int         px_taken_cnt;
	int         results_checked;
	int         mismatch_cnt;
	int         settings_cnt;
	int         cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			expected_px.size());
		$display("FAIL");
		$finish;
	end

	function automatic int src_idle_pct();
		case (idle_mode)
			IDLE_SRC:  return 46;
			IDLE_BOTH: return 10;
			default:   return 0;
		endcase
	endfunction

	function automatic int sink_stall_pct();
		case (idle_mode)
			IDLE_SINK: return 46;
			IDLE_BOTH: return 10;
			default:   return 0;
		endcase
	endfunction

	task automatic note_fail(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic box_predict(input src_px_t px);
		logic [SRC_W-1:0]   w;
		logic [SRC_W-1:0]   x;
		logic [SRC_W-1:0]   p;
		logic [LS_AW-1:0]   pi;
		logic [PAIR_W-1:0]  sa, sb, sc;
		logic [QUAD_W-1:0]  ta, tb, tc;
		logic [TOTAL_W-1:0] tot;
		box_px_t            o;
		if (width_reg < MIN_WIDTH)
			w = SRC_W'(MIN_WIDTH);
		else if (width_reg > BDS_MAX_WIDTH)
			w = SRC_W'(BDS_MAX_WIDTH);
		else
			w = width_reg;
		if (px.sof) begin
			col_cnt = '0;
			odd_row = 1'b0;
		end
		x = col_cnt;
		p = x >> 1;
		pi = p[LS_AW-1:0];
		if (!x[0]) begin
			left_px = {px.c, px.b, px.a};
		end else if (p < (w >> 1)) begin
			sa = PAIR_W'(px.a) + PAIR_W'(left_px[7:0]);
			sb = PAIR_W'(px.b) + PAIR_W'(left_px[15:8]);
			sc = PAIR_W'(px.c) + PAIR_W'(left_px[23:16]);
			if (!odd_row) begin
				line_sums[pi] = {sc, sb, sa};
			end else begin
				ta = QUAD_W'(sa) + QUAD_W'(line_sums[pi][PAIR_W-1:0]);
				tb = QUAD_W'(sb) + QUAD_W'(line_sums[pi][2*PAIR_W-1:PAIR_W]);
				tc = QUAD_W'(sc) + QUAD_W'(line_sums[pi][3*PAIR_W-1:2*PAIR_W]);
				if (gray_reg) begin
					tot = TOTAL_W'(ta) + TOTAL_W'(tb) + TOTAL_W'(tc);
					o.a = CHAN_W'(tot / GRAY_DIV);
					o.b = o.a;
					o.c = o.a;
				end else begin
					o.a = CHAN_W'(ta >> 2);
					o.b = CHAN_W'(tb >> 2);
					o.c = CHAN_W'(tc >> 2);
				end
				o.row_end = (p + 1 == (w >> 1));
				expected_px.push_back(o);
			end
		end
		col_cnt = x + SRC_W'(1);
		if (col_cnt >= w) begin
			col_cnt = '0;
			odd_row = ~odd_row;
		end
	endtask

	// monitor: config and pixel transfers feed the predictor, results are checked
	always @(posedge clk) begin
		box_px_t e;
		if (!arst_n) begin
			src_taken = 1'b0;
			cfg_taken = 1'b0;
		end else begin
			src_taken = s_tvalid && s_tready;
			cfg_taken = cfg_valid && cfg_ready;
			if (cfg_taken) begin
				if (cfg_index == CFG_IDX_SOURCE_WIDTH)
					width_reg = cfg_data;
				else if (cfg_index == CFG_IDX_GRAY_MODE)
					gray_reg = cfg_data[0];
			end
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (expected_px.size() == 0) begin
					note_fail($sformatf("unexpected result %h last=%b", m_tdata, m_tlast));
				end else begin
					e = expected_px.pop_front();
					if (m_tdata[7:0] !== e.a || m_tdata[15:8] !== e.b ||
							m_tdata[23:16] !== e.c || m_tlast !== e.row_end)
						note_fail($sformatf("mismatch exp a=%h b=%h c=%h last=%b got a=%h b=%h c=%h last=%b",
							e.a, e.b, e.c, e.row_end,
							m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast));
				end
			end
			if (src_taken) begin
				px_taken_cnt++;
				box_predict({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser});
			end
		end
	end

	// pixel source
	always @(negedge clk) begin
		src_px_t nxt;
		if (arst_n && !(s_tvalid && !src_taken)) begin
			if (pend_px.size() > 0 && $urandom_range(99) >= src_idle_pct()) begin
				nxt = pend_px.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {nxt.c, nxt.b, nxt.a};
				s_tuser  <= nxt.sof;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= sink_stall_pct());
	end

	task automatic queue_px(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic sof);
		pend_px.push_back('{a: a, b: b, c: c, sof: sof});
		px_queued_cnt++;
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic drain();
		while (px_taken_cnt != px_queued_cnt || expected_px.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// upper data bits of the gray write are junk on purpose
	task automatic set_mode(input logic [SRC_W-1:0] width, input logic gray);
		write_reg(CFG_IDX_SOURCE_WIDTH, width);
		write_reg(CFG_IDX_GRAY_MODE, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)) | gray);
		settings_cnt++;
	endtask

	// whole frames of random pixels; some are cut short by the next frame start
	task automatic gen_frames(input int w, input int n_items, input bit pause_mid);
		int done;
		int frames;
		int rows;
		int total;
		done = 0;
		frames = 0;
		while (done < n_items) begin
			rows = (w > 16) ? 2 : $urandom_range(2, 5);
			total = rows * w;
			if ($urandom_range(99) < 15)
				total = $urandom_range(1, total - 1);
			for (int k = 0; k < total; k++) begin
				if (pause_mid && frames == 1 && k == total / 2)
					drain();
				queue_px(rand_byte(), rand_byte(), rand_byte(), k == 0);
			end
			done += total;
			frames++;
		end
	endtask

	initial begin
		int widths_pool [12];
		int wsel;
		int weff;
		widths_pool = '{2, 3, 4, 5, 7, 8, 13, 16, 0, 1, 33, 64};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_mode = IDLE_NONE;
		src_taken = 1'b0;
		cfg_taken = 1'b0;
		px_queued_cnt = 0;
		px_taken_cnt = 0;
		results_checked = 0;
		mismatch_cnt = 0;
		settings_cnt = 0;
		cycle_cnt = 0;
		col_cnt = '0;
		odd_row = 1'b0;
		left_px = '0;
		width_reg = SOURCE_WIDTH_RESET;
		gray_reg = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// colour, width 4, stream starts without a frame start
		set_mode(12'd4, 1'b0);
		for (int r = 0; r < 2; r++) begin
			queue_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
			queue_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
			queue_px(8'h00, 8'h00, 8'h00, 1'b0);
			queue_px(8'h00, 8'h00, 8'h00, 1'b0);
		end
		drain();

		// gray, odd width drops the last column, unpaired last row yields nothing
		set_mode(12'd3, 1'b1);
		queue_px(8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_px(8'h07, 8'h07, 8'h07, 1'b0);
		queue_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_px(8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_px(8'h09, 8'h09, 8'h09, 1'b0);
		for (int k = 0; k < 3; k++)
			queue_px(8'h01, 8'h02, 8'h03, 1'b0);
		drain();

		// width below minimum acts as 2
		set_mode(12'd1, 1'b1);
		queue_px(8'd10, 8'd20, 8'd30, 1'b1);
		queue_px(8'd40, 8'd50, 8'd60, 1'b0);
		queue_px(8'd70, 8'd80, 8'd90, 1'b0);
		queue_px(8'd100, 8'd110, 8'd120, 1'b0);
		drain();

		// width lowered mid-row: odd column past the last pair, then the row ends
		set_mode(12'd12, 1'b0);
		for (int k = 0; k < 7; k++)
			queue_px(rand_byte(), rand_byte(), rand_byte(), k == 0);
		drain();
		write_reg(CFG_IDX_SOURCE_WIDTH, 12'd4);
		write_reg(CFG_IDX_UNUSED, 12'hFFF);
		for (int k = 0; k < 5; k++)
			queue_px(rand_byte(), rand_byte(), rand_byte(), 1'b0);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_mode = idle_mode_t'(ph % 4);
			wsel = widths_pool[$urandom_range(0, 11)];
			weff = (wsel < MIN_WIDTH) ? MIN_WIDTH : wsel;
			set_mode(SRC_W'(wsel), 1'($urandom_range(1)));
			gen_frames(weff, PHASE_ITEMS, ph % 2 == 1);
			drain();
		end

		// largest width register value, part of one row
		idle_mode = IDLE_SINK;
		set_mode(12'hFFF, 1'($urandom_range(1)));
		for (int k = 0; k < WIDE_ITEMS; k++)
			queue_px(rand_byte(), rand_byte(), rand_byte(), k == 0);
		drain();

		$display("%0d source pixels sent, %0d output pixels checked", px_taken_cnt,
			results_checked);
		$display("%0d register settings, widths 0 to 4095, colour and gray, four idle patterns",
			settings_cnt);
		if (mismatch_cnt == 0 && expected_px.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors, %0d results missing", mismatch_cnt, expected_px.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/bds_pkg.sv
sv/bds_ram.sv
sv/bds_front.sv
sv/bds_back.sv
sv/box_downsample_2x2.sv
tb/tb_box_downsample_2x2.sv
